@@ design/tfb_pkg.sv @@
package tfb_pkg;

	localparam int FRAC_BITS_DEF = 14;
	// Cross product magnitudes are scaled so that the largest lands in [2^19, 2^20).
	localparam int NORM_BITS = 20;

	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
	} in_t;

	typedef struct packed {
		logic signed [15:0] tangent_a_x;
		logic signed [15:0] tangent_a_y;
		logic signed [15:0] tangent_a_z;
		logic signed [15:0] tangent_b_x;
		logic signed [15:0] tangent_b_y;
		logic signed [15:0] tangent_b_z;
		logic signed [15:0] local_dir_x;
		logic signed [15:0] local_dir_y;
		logic signed [15:0] local_dir_z;
		logic               degenerate;
	} out_t;

	// Data that rides along with an item through the second normalizer.
	typedef struct packed {
		in_t              cmd;
		logic [2:0][15:0] ta;
		logic             zero_a;
	} side_b_t;

	// Saturation limit: one in fixed point, or the largest 16-bit value.
	function automatic int lim_fx(input int f);
		lim_fx = (f <= 14) ? (1 << f) : 32767;
	endfunction

endpackage

@@ design/tfb_unit3.sv @@
module tfb_unit3 #(
	parameter int FRAC_BITS = tfb_pkg::FRAC_BITS_DEF,
	parameter int CW = 17,
	parameter int SB_W = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [2:0][CW-1:0]    c,
	input  logic [SB_W-1:0]       sb_in,
	output logic                  out_valid,
	output logic [2:0][15:0]      t,
	output logic                  zero,
	output logic [SB_W-1:0]       sb_out
);

	localparam int NB = tfb_pkg::NORM_BITS;
	localparam int PW = $clog2(CW);
	localparam int SQ_W = 2 * NB + 2;
	localparam int SQ_N = NB + 1;
	localparam int LEN_W = NB + 1;
	localparam int QW = FRAC_BITS + 2;
	localparam int RW = NB + FRAC_BITS + 2;
	localparam int LIM = tfb_pkg::lim_fx(FRAC_BITS);

	typedef struct packed {
		logic [2:0] neg;
		logic       zero;
		logic [SB_W-1:0] sb;
	} side_t;

	// Stage 1: magnitudes and signs.
	logic            v_s1;
	logic [2:0][CW-1:0] m_s1;
	logic [2:0]      neg_s1;
	logic [SB_W-1:0] sb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= c[i][CW-1];
			m_s1[i]   <= c[i][CW-1] ? (~c[i] + CW'(1)) : c[i];
		end
		sb_s1 <= sb_in;
	end

	// Stage 2: position of the leading one of the largest magnitude.
	logic [CW-1:0] or_m;
	logic [PW-1:0] pos_c;

	always_comb begin
		or_m  = m_s1[0] | m_s1[1] | m_s1[2];
		pos_c = '0;
		for (int j = 0; j < CW; j++) begin
			if (or_m[j]) begin
				pos_c = PW'(j);
			end
		end
	end

	logic               v_s2;
	logic [2:0][CW-1:0] m_s2;
	logic [PW-1:0]      pos_s2;
	side_t              sd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		m_s2         <= m_s1;
		pos_s2       <= pos_c;
		sd_s2.neg    <= neg_s1;
		sd_s2.zero   <= (or_m == '0);
		sd_s2.sb     <= sb_s1;
	end

	// Stage 3: shift every component by the same amount.
	logic [2:0][NB-1:0] mn_c;

	always_comb begin
		logic [CW+NB-1:0] ext;
		for (int i = 0; i < 3; i++) begin
			ext = (CW+NB)'(m_s2[i]);
			if (int'(pos_s2) > NB - 1) begin
				ext = ext >> (int'(pos_s2) - (NB - 1));
			end else begin
				ext = ext << ((NB - 1) - int'(pos_s2));
			end
			mn_c[i] = ext[NB-1:0];
		end
	end

	logic               v_s3;
	logic [2:0][NB-1:0] mn_s3;
	side_t              sd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		mn_s3 <= mn_c;
		sd_s3 <= sd_s2;
	end

	// Stage 4: squares. Stage 5: squared length.
	logic                 v_s4;
	logic [2:0][NB-1:0]   mn_s4;
	logic [2:0][2*NB-1:0] sq_s4;
	side_t                sd_s4;
	logic                 v_s5;
	logic [2:0][NB-1:0]   mn_s5;
	logic [SQ_W-1:0]      len2_s5;
	side_t                sd_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s4[i] <= mn_s3[i] * mn_s3[i];
		end
		mn_s4   <= mn_s3;
		sd_s4   <= sd_s3;
		len2_s5 <= SQ_W'(sq_s4[0]) + SQ_W'(sq_s4[1]) + SQ_W'(sq_s4[2]);
		mn_s5   <= mn_s4;
		sd_s5   <= sd_s4;
	end

	// Integer square root, one result bit per stage.
	logic               rt_v_s   [SQ_N+1];
	logic [SQ_W-1:0]    rt_val_s [SQ_N+1];
	logic [SQ_W-1:0]    rt_res_s [SQ_N+1];
	logic [2:0][NB-1:0] rt_m_s   [SQ_N+1];
	side_t              rt_sd_s  [SQ_N+1];

	assign rt_v_s[0]   = v_s5;
	assign rt_val_s[0] = len2_s5;
	assign rt_res_s[0] = '0;
	assign rt_m_s[0]   = mn_s5;
	assign rt_sd_s[0]  = sd_s5;

	for (genvar k = 0; k < SQ_N; k++) begin : g_root
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
		logic [SQ_W-1:0] trial;

		assign trial = rt_res_s[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[k+1] <= 1'b0;
			end else begin
				rt_v_s[k+1] <= rt_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rt_val_s[k] >= trial) begin
				rt_val_s[k+1] <= rt_val_s[k] - trial;
				rt_res_s[k+1] <= (rt_res_s[k] >> 1) + BIT;
			end else begin
				rt_val_s[k+1] <= rt_val_s[k];
				rt_res_s[k+1] <= rt_res_s[k] >> 1;
			end
			rt_m_s[k+1]  <= rt_m_s[k];
			rt_sd_s[k+1] <= rt_sd_s[k];
		end
	end

	// Dividends with the half-divisor rounding term, then restoring division.
	logic [LEN_W-1:0] len_c;

	assign len_c = rt_res_s[SQ_N][LEN_W-1:0];

	logic               dv_v_s   [QW+1];
	logic [2:0][RW-1:0] dv_rem_s [QW+1];
	logic [2:0][QW-1:0] dv_q_s   [QW+1];
	logic [LEN_W-1:0]   dv_len_s [QW+1];
	side_t              dv_sd_s  [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else begin
			dv_v_s[0] <= rt_v_s[SQ_N];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dv_rem_s[0][i] <= (RW'(rt_m_s[SQ_N][i]) << FRAC_BITS) + RW'(len_c >> 1);
		end
		dv_q_s[0]   <= '0;
		dv_len_s[0] <= len_c;
		dv_sd_s[0]  <= rt_sd_s[SQ_N];
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		localparam int QB = QW - 1 - k;
		localparam logic [QW-1:0] QMASK = QW'(1) << QB;
		logic [RW-1:0] dsh;

		assign dsh = RW'(dv_len_s[k]) << QB;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				if (dv_rem_s[k][i] >= dsh) begin
					dv_rem_s[k+1][i] <= dv_rem_s[k][i] - dsh;
					dv_q_s[k+1][i]   <= dv_q_s[k][i] | QMASK;
				end else begin
					dv_rem_s[k+1][i] <= dv_rem_s[k][i];
					dv_q_s[k+1][i]   <= dv_q_s[k][i];
				end
			end
			dv_len_s[k+1] <= dv_len_s[k];
			dv_sd_s[k+1]  <= dv_sd_s[k];
		end
	end

	// Clamp, sign and zero-vector override.
	logic [2:0][15:0] t_q;
	logic             v_q;
	side_t            sd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= dv_v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		logic [15:0] s;
		for (int i = 0; i < 3; i++) begin
			s = (dv_q_s[QW][i] > QW'(LIM)) ? 16'(LIM) : 16'(dv_q_s[QW][i]);
			if (dv_sd_s[QW].zero) begin
				t_q[i] <= '0;
			end else begin
				t_q[i] <= dv_sd_s[QW].neg[i] ? (~s + 16'd1) : s;
			end
		end
		sd_q <= dv_sd_s[QW];
	end

	assign out_valid = v_q;
	assign t         = t_q;
	assign zero      = sd_q.zero;
	assign sb_out    = sd_q.sb;

endmodule

@@ design/tangent_frame_build_and_project_unit.sv @@
// Throughput: one item per cycle; every stage is registered and busy never rises.
// Each normalizer runs a one-bit-per-stage square root and a one-bit-per-stage divider.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
// Results appear on result for one cycle with done; the receiver cannot stall.
module tangent_frame_build_and_project_unit #(
	parameter int FRAC_BITS = tfb_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  tfb_pkg::in_t cmd,
	output logic         done,
	output tfb_pkg::out_t result
);

	localparam int CA_W = 17;
	localparam int CB_W = 33;
	localparam int LIM = tfb_pkg::lim_fx(FRAC_BITS);
	localparam logic signed [15:0] LIM16 = 16'(LIM);

	assign busy = 1'b0;

	// Stage 1: input register.
	logic         v_s1;
	tfb_pkg::in_t cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd;
	end

	// First cross product against the chosen helper vector.
	logic [2:0][CA_W-1:0] c1;

	always_comb begin
		logic signed [CA_W-1:0] nx, ny, nz;
		nx = CA_W'(cmd_s1.normal_x);
		ny = CA_W'(cmd_s1.normal_y);
		nz = CA_W'(cmd_s1.normal_z);
		if (nz != '0) begin
			c1[0] = nz;
			c1[1] = '0;
			c1[2] = -nx;
		end else begin
			c1[0] = -ny;
			c1[1] = nx;
			c1[2] = '0;
		end
	end

	logic             va;
	logic [2:0][15:0] ta;
	logic             za;
	tfb_pkg::in_t     sba;

	tfb_unit3 #(
		.FRAC_BITS(FRAC_BITS),
		.CW(CA_W),
		.SB_W($bits(tfb_pkg::in_t))
	) u_norm_a (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s1),
		.c(c1),
		.sb_in(cmd_s1),
		.out_valid(va),
		.t(ta),
		.zero(za),
		.sb_out(sba)
	);

	// Stage 2: products for n x a. Stage 3: differences.
	logic               v_s2;
	logic signed [31:0] p_s2 [6];
	tfb_pkg::side_b_t   sd_s2;
	logic               v_s3;
	logic [2:0][CB_W-1:0] c2_s3;
	tfb_pkg::side_b_t   sd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= va;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		p_s2[0] <= sba.normal_y * $signed(ta[2]);
		p_s2[1] <= sba.normal_z * $signed(ta[1]);
		p_s2[2] <= sba.normal_z * $signed(ta[0]);
		p_s2[3] <= sba.normal_x * $signed(ta[2]);
		p_s2[4] <= sba.normal_x * $signed(ta[1]);
		p_s2[5] <= sba.normal_y * $signed(ta[0]);
		sd_s2.cmd    <= sba;
		sd_s2.ta     <= ta;
		sd_s2.zero_a <= za;
		c2_s3[0] <= CB_W'(p_s2[0]) - CB_W'(p_s2[1]);
		c2_s3[1] <= CB_W'(p_s2[2]) - CB_W'(p_s2[3]);
		c2_s3[2] <= CB_W'(p_s2[4]) - CB_W'(p_s2[5]);
		sd_s3 <= sd_s2;
	end

	logic             vb;
	logic [2:0][15:0] tb;
	logic             zb;
	tfb_pkg::side_b_t sbb;

	tfb_unit3 #(
		.FRAC_BITS(FRAC_BITS),
		.CW(CB_W),
		.SB_W($bits(tfb_pkg::side_b_t))
	) u_norm_b (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s3),
		.c(c2_s3),
		.sb_in(sd_s3),
		.out_valid(vb),
		.t(tb),
		.zero(zb),
		.sb_out(sbb)
	);

	// Stage 4: dot product terms. Stage 5: sums. Stage 6: round and saturate.
	logic               v_s4;
	logic signed [31:0] dp_s4 [9];
	logic [2:0][15:0]   ta_s4, tb_s4;
	logic               deg_s4;
	logic               v_s5;
	logic signed [33:0] ds_s5 [3];
	logic [2:0][15:0]   ta_s5, tb_s5;
	logic               deg_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s4 <= vb;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		dp_s4[0] <= $signed(sbb.ta[0]) * sbb.cmd.dir_x;
		dp_s4[1] <= $signed(sbb.ta[1]) * sbb.cmd.dir_y;
		dp_s4[2] <= $signed(sbb.ta[2]) * sbb.cmd.dir_z;
		dp_s4[3] <= $signed(tb[0]) * sbb.cmd.dir_x;
		dp_s4[4] <= $signed(tb[1]) * sbb.cmd.dir_y;
		dp_s4[5] <= $signed(tb[2]) * sbb.cmd.dir_z;
		dp_s4[6] <= sbb.cmd.normal_x * sbb.cmd.dir_x;
		dp_s4[7] <= sbb.cmd.normal_y * sbb.cmd.dir_y;
		dp_s4[8] <= sbb.cmd.normal_z * sbb.cmd.dir_z;
		ta_s4  <= sbb.ta;
		tb_s4  <= tb;
		deg_s4 <= sbb.zero_a | zb;
		for (int i = 0; i < 3; i++) begin
			ds_s5[i] <= 34'(dp_s4[3*i]) + 34'(dp_s4[3*i+1]) + 34'(dp_s4[3*i+2]);
		end
		ta_s5  <= ta_s4;
		tb_s5  <= tb_s4;
		deg_s5 <= deg_s4;
	end

	// Round half away from zero, negate, saturate.
	function automatic logic [15:0] neg_round(input logic signed [33:0] s);
		logic [33:0] mag;
		logic [33:0] m;
		logic [15:0] r;
		mag = s[33] ? (~s + 34'd1) : s;
		m = (mag + (34'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		r = (m > 34'(LIM)) ? 16'(LIM) : m[15:0];
		neg_round = s[33] ? r : (~r + 16'd1);
	endfunction

	logic          done_q;
	tfb_pkg::out_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		result_q.tangent_a_x <= ta_s5[0];
		result_q.tangent_a_y <= ta_s5[1];
		result_q.tangent_a_z <= ta_s5[2];
		result_q.tangent_b_x <= tb_s5[0];
		result_q.tangent_b_y <= tb_s5[1];
		result_q.tangent_b_z <= tb_s5[2];
		result_q.local_dir_x <= neg_round(ds_s5[0]);
		result_q.local_dir_y <= neg_round(ds_s5[1]);
		result_q.local_dir_z <= neg_round(ds_s5[2]);
		result_q.degenerate  <= deg_s5;
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef ASSERT_OFF
	// A degenerate frame always reports a zero second tangent.
	a_deg_tb_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.degenerate |->
			result.tangent_b_x == '0 && result.tangent_b_y == '0 && result.tangent_b_z == '0)
		else $error("degenerate item with nonzero second tangent");

	// A frame that is not degenerate has a nonzero first tangent.
	a_ta_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.degenerate |->
			result.tangent_a_x != '0 || result.tangent_a_y != '0 || result.tangent_a_z != '0)
		else $error("regular item with zero first tangent");

	// The third projection (local_dir_z) stays within the saturation limit.
	a_loc_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.local_dir_z <= LIM16 && result.local_dir_z >= -LIM16)
		else $error("local direction out of range");
`endif

endmodule

@@ verif/tangent_frame_checker.sv @@
module tangent_frame_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  tfb_pkg::in_t  cmd,
	input  logic          done,
	input  tfb_pkg::out_t result,
	output int            fail_count,
	output int            pending
);

	localparam int FB = tfb_pkg::FRAC_BITS_DEF;
	localparam longint LIMV = (FB <= 14) ? (64'sd1 << FB) : 64'sd32767;

	tfb_pkg::out_t frames_due[$];
	int fails_q = 0;

	function automatic longint mag(input longint v);
		mag = (v < 0) ? -v : v;
	endfunction

	function automatic longint clamp_fx(input longint v);
		if (v > LIMV)
			clamp_fx = LIMV;
		else if (v < -LIMV)
			clamp_fx = -LIMV;
		else
			clamp_fx = v;
	endfunction

	function automatic longint int_sqrt(input longint v);
		longint r, b, x;
		r = 0;
		x = v;
		b = 64'sd1 << 62;
		while (b > x)
			b = b >>> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		int_sqrt = r;
	endfunction

	// Returns 0 when the vector is zero; t is then all zero.
	function automatic bit normalize(input longint c[3], output longint t[3]);
		longint m[3], mx, len, q;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = mag(c[i]);
			if (m[i] > mx)
				mx = m[i];
			t[i] = 0;
		end
		if (mx == 0)
			return 0;
		while (mx >= (64'sd1 << 20)) begin
			for (int i = 0; i < 3; i++)
				m[i] = m[i] >>> 1;
			mx = mx >>> 1;
		end
		while (mx < (64'sd1 << 19)) begin
			for (int i = 0; i < 3; i++)
				m[i] = m[i] << 1;
			mx = mx << 1;
		end
		len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << FB) + (len >>> 1)) / len;
			if (q > LIMV)
				q = LIMV;
			t[i] = (c[i] < 0) ? -q : q;
		end
		return 1;
	endfunction

	function automatic longint flipped_dot(input longint a[3], input longint b[3]);
		longint s, r;
		s = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
		r = (mag(s) + (64'sd1 << (FB - 1))) >>> FB;
		if (s < 0)
			r = -r;
		flipped_dot = clamp_fx(-r);
	endfunction

	function automatic tfb_pkg::out_t build_frame(input tfb_pkg::in_t c);
		longint n[3], d[3], c1[3], c2[3], ta[3], tb[3];
		bit ok_a, ok_b;
		tfb_pkg::out_t o;
		n[0] = c.normal_x;
		n[1] = c.normal_y;
		n[2] = c.normal_z;
		d[0] = c.dir_x;
		d[1] = c.dir_y;
		d[2] = c.dir_z;
		if (n[2] != 0) begin
			c1[0] = n[2];
			c1[1] = 0;
			c1[2] = -n[0];
		end else begin
			c1[0] = -n[1];
			c1[1] = n[0];
			c1[2] = 0;
		end
		ok_a = normalize(c1, ta);
		c2[0] = n[1] * ta[2] - n[2] * ta[1];
		c2[1] = n[2] * ta[0] - n[0] * ta[2];
		c2[2] = n[0] * ta[1] - n[1] * ta[0];
		ok_b = normalize(c2, tb);
		o.tangent_a_x = ta[0][15:0];
		o.tangent_a_y = ta[1][15:0];
		o.tangent_a_z = ta[2][15:0];
		o.tangent_b_x = tb[0][15:0];
		o.tangent_b_y = tb[1][15:0];
		o.tangent_b_z = tb[2][15:0];
		o.local_dir_x = 16'(flipped_dot(ta, d));
		o.local_dir_y = 16'(flipped_dot(tb, d));
		o.local_dir_z = 16'(flipped_dot(n, d));
		o.degenerate = !(ok_a && ok_b);
		return o;
	endfunction

	assign pending = frames_due.size();
	assign fail_count = fails_q;

	always @(posedge clk) begin
		tfb_pkg::out_t want;
		if (arst_n) begin
			if (start && !busy)
				frames_due.push_back(build_frame(cmd));
			if (done) begin
				if (frames_due.size() == 0) begin
					fails_q <= fails_q + 1;
					if (fails_q < 10)
						$display("unexpected frame %h", result);
				end else begin
					want = frames_due.pop_front();
					if (want !== result) begin
						fails_q <= fails_q + 1;
						if (fails_q < 10)
							$display("frame mismatch: expected %h actual %h", want, result);
					end
				end
			end
		end
	end
endmodule

@@ verif/tangent_frame_build_and_project_unit_test.sv @@
module tangent_frame_build_and_project_unit_test;

	localparam int LATENCY = 66 + 2 * tfb_pkg::FRAC_BITS_DEF;
	localparam int IDLE_LIMIT = 20 * LATENCY + 2000;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	tfb_pkg::in_t cmd = '0;
	logic busy, done;
	tfb_pkg::out_t result;
	int fail_count, pending;
	int idle_cycles = 0;

	tangent_frame_build_and_project_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .result(result)
	);

	tangent_frame_checker u_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .fail_count(fail_count), .pending(pending)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("tangent_frame_build_and_project_unit_test failed");
			$finish;
		end
	end

	function automatic logic signed [15:0] rand_q(input int kind);
		case (kind)
			0: rand_q = 16'sd16384;
			1: rand_q = -16'sd16384;
			2: rand_q = 16'sd0;
			3: rand_q = 16'($urandom_range(0, 32768) - 16384);
			4: rand_q = 16'($urandom_range(0, 64) - 32);
			default: rand_q = 16'($urandom());
		endcase
	endfunction

	// Mostly unit normals with random direction; some raw noise and tiny values.
	function automatic tfb_pkg::in_t random_item();
		tfb_pkg::in_t c;
		real nx, ny, nz, len;
		int k;
		k = $urandom_range(0, 9);
		if (k < 7) begin
			nx = $urandom_range(0, 2000) - 1000.0;
			ny = $urandom_range(0, 2000) - 1000.0;
			nz = ($urandom_range(0, 4) == 0) ? 0.0 : $urandom_range(0, 2000) - 1000.0;
			len = $sqrt(nx * nx + ny * ny + nz * nz);
			if (len == 0.0) begin
				nx = 1.0;
				len = 1.0;
			end
			c.normal_x = 16'($rtoi(nx / len * 16384.0));
			c.normal_y = 16'($rtoi(ny / len * 16384.0));
			c.normal_z = 16'($rtoi(nz / len * 16384.0));
		end else begin
			c.normal_x = rand_q($urandom_range(0, 5));
			c.normal_y = rand_q($urandom_range(0, 5));
			c.normal_z = rand_q($urandom_range(0, 5));
		end
		c.dir_x = rand_q($urandom_range(0, 5));
		c.dir_y = rand_q($urandom_range(0, 5));
		c.dir_z = rand_q($urandom_range(0, 5));
		return c;
	endfunction

	task automatic send(input tfb_pkg::in_t c);
		start <= 1;
		cmd <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic pause(input int n);
		start <= 0;
		repeat (n) @(posedge clk);
	endtask

	initial begin
		int burst;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Axis normals (both helper choices), zero normal, extremes, full-scale words.
		send('{16'sd0, 16'sd0, 16'sd16384, 16'sd16384, -16'sd16384, 16'sd0});
		send('{16'sd0, 16'sd0, -16'sd16384, -16'sd16384, 16'sd16384, 16'sd16384});
		send('{16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd16384, -16'sd16384});
		send('{16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd16384});
		send('{16'sd0, 16'sd0, 16'sd0, 16'sd100, 16'sd200, 16'sd300});
		send('{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
		send('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
		send('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
		send('{16'sh8000, 16'sh7fff, 16'sd0, 16'sh7fff, 16'sh8000, 16'sd1});
		send('{16'sd1, 16'sd0, 16'sd0, -16'sd1, 16'sd1, -16'sd1});
		send('{16'sd1, 16'sd0, 16'sd1, 16'sd1, 16'sd1, 16'sd1});
		send('{16'sd11585, 16'sd0, 16'sd11585, 16'sd16384, 16'sd0, 16'sd16384});
		send('{16'sd9459, 16'sd9459, 16'sd9459, -16'sd9459, 16'sd9459, -16'sd9459});
		send('{-16'sd1, 16'sh7fff, 16'sd0, 16'sh7fff, 16'sh7fff, 16'sh7fff});

		// Let everything drain once before the random part.
		pause(1);
		while (pending != 0)
			@(posedge clk);

		for (int i = 0; i < 1800; ) begin
			burst = ($urandom_range(0, 5) == 0) ? 100 : $urandom_range(1, 20);
			for (int j = 0; j < burst && i < 1800; j++, i++)
				send(random_item());
			if ($urandom_range(0, 3) != 0)
				pause($urandom_range(1, 6));
		end
		start <= 0;

		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0)
			$display("tangent_frame_build_and_project_unit_test passed");
		else
			$display("tangent_frame_build_and_project_unit_test failed");
		$finish;
	end
endmodule
